>>> src/utf8_line_index_table_unit_macros.svh
// Assertion macros used by the checker of the line index table.
`ifndef UTF8_LINE_INDEX_TABLE_UNIT_MACROS_SVH
`define UTF8_LINE_INDEX_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ULI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ULI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/uli_pkg.sv
`timescale 1ns / 1ps
package uli_pkg;

  localparam int MAX_LINES_DEF = 256;
  localparam int MAX_BYTES_DEF = 65536;

  localparam int CNT_W = 17;

  typedef enum logic [1:0] {
    CMD_BYTE   = 2'd0,
    CMD_FINISH = 2'd1,
    CMD_COLUMN = 2'd2,
    CMD_LINE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_PAST = 2'd2
  } stat_t;

  // Register select: paddr bit 2 picks the word.
  localparam logic CFG_SEL_TEXT_LENGTH = 1'b0;

  localparam logic [7:0] LEAD1_MASK = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_CODE = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_CODE = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_CODE = 8'hF0;
  localparam logic [7:0] NEWLINE    = 8'h0A;

  // Line record to write into the span memories.
  typedef struct packed {
    logic             wr;
    stat_t            status;
    logic [CNT_W-1:0] bstart;
    logic [CNT_W-1:0] bstop;
    logic [CNT_W-1:0] cstart;
    logic [CNT_W-1:0] cstop;
  } push_t;

  // Bytes claimed by a lead byte, itself included.
  function automatic logic [2:0] seq_len(input logic [7:0] c);
    logic [2:0] n;
    if ((c & LEAD1_MASK) == 8'h00) n = 3'd1;
    else if ((c & LEAD2_MASK) == LEAD2_CODE) n = 3'd2;
    else if ((c & LEAD3_MASK) == LEAD3_CODE) n = 3'd3;
    else if ((c & LEAD4_MASK) == LEAD4_CODE) n = 3'd4;
    else n = 3'd1;
    return n;
  endfunction

endpackage

>>> src/utf8_line_index_table_unit.sv
`timescale 1ns / 1ps
// UTF-8 line index table.
// Requests enter on start while busy is low; the command picks text byte,
// finish, column query or line query. One result per request comes out on
// out_* for exactly one cycle, marked by out_valid; the receiver cannot stall,
// so it must take the result in that cycle.
// Results and rate:
//   text byte, finish : result in the cycle after the request, busy stays low, so
//                       one request per cycle is taken.
//   line query        : result after one span memory read and the output register.
//   column query      : result after the compare that finds the line or reaches the
//                       last entry; the line table is walked one entry a cycle
//                       through the char span memory port.
// busy is high while a query waits on the memories.
// The text length register is written over the APB port (paddr[2] low); the
// user must write it only while the block is idle, which it does not enforce.
// Reset clears the counters, the line count and the register; the span
// memories are not cleared, since only entries below the line count are ever used.
module utf8_line_index_table_unit #(
  parameter int MAX_LINES = uli_pkg::MAX_LINES_DEF,
  parameter int MAX_BYTES = uli_pkg::MAX_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // request channel
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_command,
  input  logic [7:0]         in_data_byte,
  input  logic signed [17:0] in_char_position,
  input  logic signed [17:0] in_target_line,
  // result channel
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic [7:0]         out_line_index,
  output logic [16:0]        out_column,
  output logic [16:0]        out_span_byte_start,
  output logic [16:0]        out_span_byte_end,
  output logic [16:0]        out_span_char_start,
  output logic [8:0]         out_line_total,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import uli_pkg::*;

  localparam int AW = $clog2(MAX_LINES);
  localparam int CW = $clog2(MAX_LINES + 1);
  localparam int SW = 2 * CNT_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_LOOK = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  logic [CW-1:0]    line_count_r, line_count_nxt;
  logic [CNT_W-1:0] text_length_r;
  logic [AW-1:0]    idx_r, idx_nxt;
  logic signed [17:0] pos_r;

  logic             accept;
  cmd_t             cmd;
  logic [CNT_W-1:0] text_end;
  logic             full;
  push_t            push;

  logic [AW-1:0]    rd_addr;
  logic [SW-1:0]    byte_rd;
  logic [SW-1:0]    char_rd;

  logic signed [19:0] tgt_s, lim_s, k_s;
  logic signed [18:0] pos_s, s_s, e_s, d_s, w_s;
  logic             hit, last;

  logic             out_valid_r, out_valid_nxt;
  stat_t            out_status_r, out_status_nxt;
  logic [AW-1:0]    out_lidx_r, out_lidx_nxt;
  logic [CNT_W-1:0] out_col_r, out_col_nxt;
  logic [CNT_W-1:0] out_bs_r, out_bs_nxt;
  logic [CNT_W-1:0] out_be_r, out_be_nxt;
  logic [CNT_W-1:0] out_cs_r, out_cs_nxt;
  logic [8:0]       out_total_r, out_total_nxt;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start & !busy;
  assign cmd    = cmd_t'(in_command);

  // Text end is the configured length, capped by the byte capacity.
  assign text_end = (32'(text_length_r) < 32'(MAX_BYTES)) ? text_length_r
                                                          : CNT_W'(MAX_BYTES);
  assign full     = (line_count_r >= CW'(MAX_LINES));

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign prdata = (paddr[2] == CFG_SEL_TEXT_LENGTH) ? 32'(text_length_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_length_r <= '0;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == CFG_SEL_TEXT_LENGTH) begin
      text_length_r <= pwdata[CNT_W-1:0];
    end
  end

  // ---------------- byte stream counters ----------------
  uli_text u_text (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (accept && (cmd == CMD_BYTE || cmd == CMD_FINISH)),
    .finish    (cmd == CMD_FINISH),
    .data_byte (in_data_byte),
    .text_end  (text_end),
    .full      (full),
    .push      (push)
  );

  // ---------------- span memories ----------------
  // Both memories are written together at the line count; start in the high
  // half, end in the low half.
  uli_ram #(.WIDTH(SW), .DEPTH(MAX_LINES)) u_byte_ram (
    .clk   (clk),
    .we    (push.wr),
    .waddr (line_count_r[AW-1:0]),
    .wdata ({push.bstart, push.bstop}),
    .raddr (rd_addr),
    .rdata (byte_rd)
  );

  uli_ram #(.WIDTH(SW), .DEPTH(MAX_LINES)) u_char_ram (
    .clk   (clk),
    .we    (push.wr),
    .waddr (line_count_r[AW-1:0]),
    .wdata ({push.cstart, push.cstop}),
    .raddr (rd_addr),
    .rdata (char_rd)
  );

  // Clamp the line query index into the table.
  assign tgt_s = 20'(in_target_line);
  assign lim_s = $signed(20'(line_count_r)) - 20'sd1;
  always_comb begin
    if (tgt_s < 20'sd0) k_s = 20'sd0;
    else if (tgt_s > lim_s) k_s = lim_s;
    else k_s = tgt_s;
  end

  // Read address: first entry or clamped index on a request, then walk ahead
  // of the entry being compared.
  always_comb begin
    case (state_r)
      ST_IDLE: rd_addr = (cmd == CMD_LINE) ? AW'(k_s) : '0;
      ST_SCAN: rd_addr = idx_r + 1'b1;
      default: rd_addr = idx_r;
    endcase
  end

  // Column compare on the entry read last cycle.
  assign pos_s = 19'(pos_r);
  assign s_s   = $signed({2'b00, char_rd[SW-1:CNT_W]});
  assign e_s   = $signed({2'b00, char_rd[CNT_W-1:0]});
  assign w_s   = e_s - s_s;
  assign hit   = (pos_s <= e_s);
  assign last  = (CW'(idx_r) == line_count_r - 1'b1);

  always_comb begin
    d_s = pos_s - s_s;
    if (d_s < 19'sd0) d_s = 19'sd0;
    if (d_s > w_s) d_s = w_s;
  end

  // ---------------- control ----------------
  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    line_count_nxt = line_count_r + CW'(push.wr);
    out_valid_nxt  = 1'b0;
    out_status_nxt = STAT_OK;
    out_lidx_nxt   = '0;
    out_col_nxt    = '0;
    out_bs_nxt     = '0;
    out_be_nxt     = '0;
    out_cs_nxt     = '0;
    out_total_nxt  = 9'(line_count_nxt);
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (cmd)
            CMD_BYTE, CMD_FINISH: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = push.status;
            end
            CMD_COLUMN: begin
              idx_nxt   = '0;
              state_nxt = ST_SCAN;
            end
            default: begin
              idx_nxt   = AW'(k_s);
              state_nxt = ST_LOOK;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (line_count_r == '0 || hit || last) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          if (line_count_r != '0) begin
            out_lidx_nxt = idx_r;
            out_col_nxt  = d_s[CNT_W-1:0];
          end
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_LOOK: begin
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
        if (line_count_r != '0) begin
          out_lidx_nxt = idx_r;
          out_bs_nxt   = byte_rd[SW-1:CNT_W];
          out_be_nxt   = byte_rd[CNT_W-1:0];
          out_cs_nxt   = char_rd[SW-1:CNT_W];
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      line_count_r <= '0;
      idx_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      line_count_r <= line_count_nxt;
      idx_r        <= idx_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Hold the query position and the result payload; no reset needed.
  always_ff @(posedge clk) begin
    if (accept && cmd == CMD_COLUMN) begin
      pos_r <= in_char_position;
    end
    out_status_r <= out_status_nxt;
    out_lidx_r   <= out_lidx_nxt;
    out_col_r    <= out_col_nxt;
    out_bs_r     <= out_bs_nxt;
    out_be_r     <= out_be_nxt;
    out_cs_r     <= out_cs_nxt;
    out_total_r  <= out_total_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_line_index      = 8'(out_lidx_r);
  assign out_column          = out_col_r;
  assign out_span_byte_start = out_bs_r;
  assign out_span_byte_end   = out_be_r;
  assign out_span_char_start = out_cs_r;
  assign out_line_total      = out_total_r;

endmodule

>>> src/uli_ram.sv
`timescale 1ns / 1ps
module uli_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/uli_text.sv
`timescale 1ns / 1ps
module uli_text (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    step,
  input  logic                    finish,
  input  logic [7:0]              data_byte,
  input  logic [uli_pkg::CNT_W-1:0] text_end,
  input  logic                    full,
  output uli_pkg::push_t          push
);
  import uli_pkg::*;

  logic [CNT_W-1:0] byte_cnt_r, byte_cnt_nxt;
  logic [CNT_W-1:0] char_cnt_r, char_cnt_nxt;
  logic [1:0]       skip_r, skip_nxt;
  logic [CNT_W-1:0] open_byte_r, open_byte_nxt;
  logic [CNT_W-1:0] open_char_r, open_char_nxt;
  logic [2:0]       n;

  always_comb begin
    byte_cnt_nxt  = byte_cnt_r;
    char_cnt_nxt  = char_cnt_r;
    skip_nxt      = skip_r;
    open_byte_nxt = open_byte_r;
    open_char_nxt = open_char_r;
    push          = '0;
    push.status   = STAT_OK;
    n             = seq_len(data_byte);
    if (finish) begin
      push.wr     = step & !full;
      push.status = full ? STAT_FULL : STAT_OK;
      push.bstart = open_byte_r;
      push.bstop  = byte_cnt_r;
      push.cstart = open_char_r;
      push.cstop  = char_cnt_r;
      open_byte_nxt = byte_cnt_r;
      open_char_nxt = char_cnt_r;
    end else if (byte_cnt_r >= text_end) begin
      push.status = STAT_PAST;
    end else if (skip_r != 2'd0) begin
      skip_nxt     = skip_r - 2'd1;
      byte_cnt_nxt = byte_cnt_r + 1'b1;
    end else begin
      // truncated sequence at the text end counts as a single byte
      if (({1'b0, byte_cnt_r} + (CNT_W+1)'(n)) > {1'b0, text_end}) begin
        n = 3'd1;
      end
      byte_cnt_nxt = byte_cnt_r + 1'b1;
      char_cnt_nxt = char_cnt_r + 1'b1;
      skip_nxt     = 2'(n - 3'd1);
      if (data_byte == NEWLINE) begin
        push.wr     = step & !full;
        push.status = full ? STAT_FULL : STAT_OK;
        push.bstart = open_byte_r;
        push.bstop  = byte_cnt_r;
        push.cstart = open_char_r;
        push.cstop  = char_cnt_r;
        open_byte_nxt = byte_cnt_nxt;
        open_char_nxt = char_cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_cnt_r  <= '0;
      char_cnt_r  <= '0;
      skip_r      <= '0;
      open_byte_r <= '0;
      open_char_r <= '0;
    end else if (step) begin
      byte_cnt_r  <= byte_cnt_nxt;
      char_cnt_r  <= char_cnt_nxt;
      skip_r      <= skip_nxt;
      open_byte_r <= open_byte_nxt;
      open_char_r <= open_char_nxt;
    end
  end

endmodule

>>> src/uli_chk.sv
`timescale 1ns / 1ps
`include "utf8_line_index_table_unit_macros.svh"
module uli_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [1:0]  in_command,
  input logic        out_valid,
  input logic [1:0]  out_status,
  input logic [7:0]  out_line_index,
  input logic [16:0] out_column
);
  import uli_pkg::*;

  logic stream_req;
  logic line_req;
  logic status_known;
  logic err_result;
  logic query_clear;

  assign stream_req   = start && !busy &&
                        (in_command == CMD_BYTE || in_command == CMD_FINISH);
  assign line_req     = start && !busy && in_command == CMD_LINE;
  assign status_known = out_status == STAT_OK || out_status == STAT_FULL ||
                        out_status == STAT_PAST;
  assign err_result   = out_valid && out_status != STAT_OK;
  assign query_clear  = out_line_index == 8'd0 && out_column == 17'd0;

  `ULI_ASSERT_NXT(a_stream_resp, stream_req, out_valid, "text request without result next cycle")
  `ULI_ASSERT_NXT(a_line_wait, line_req, busy && !out_valid, "line query answered early")
  `ULI_ASSERT_IMP(a_status_code, out_valid, status_known, "undefined status code")
  `ULI_ASSERT_IMP(a_error_fields, err_result, query_clear, "query fields on an error result")

endmodule

bind utf8_line_index_table_unit uli_chk u_chk (.*);
